### rtl/q2e_pkg.sv
package q2e_pkg;

   // working scale: 30 fraction bits, headroom for CORDIC gain on |v| up to about 5
   localparam int WFRAC      = 30;
   localparam int WORK_W     = 40;
   localparam int PROD_W     = 32;
   localparam int ROOT_W     = 62;
   localparam int SQRT_STEPS = 31;
   localparam int Q13_SHIFT  = 17;
   localparam int ATAN_DEPTH = 32;

   localparam logic signed [WORK_W-1:0] ONE_W      = 40'sd1073741824;
   localparam logic signed [WORK_W-1:0] PI_W       = 40'sd3373259426;
   localparam logic signed [WORK_W-1:0] ROUND_HALF = 40'sd65536;
   localparam logic signed [WORK_W-1:0] PI_Q13     = 40'sd25736;
   localparam logic signed [WORK_W-1:0] HALF_PI_Q13 = 40'sd12868;

   localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
      32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
      32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
      32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
      32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
   };

   typedef struct packed {
      logic                     valid;
      logic signed [WORK_W-1:0] roll_x;
      logic signed [WORK_W-1:0] roll_y;
      logic signed [WORK_W-1:0] roll_z;
      logic signed [WORK_W-1:0] yaw_x;
      logic signed [WORK_W-1:0] yaw_y;
      logic signed [WORK_W-1:0] yaw_z;
      logic signed [WORK_W-1:0] pit_x;
      logic signed [WORK_W-1:0] pit_y;
      logic signed [WORK_W-1:0] pit_z;
      logic [ROOT_W-1:0]        rad_v;
      logic [ROOT_W-1:0]        rad_r;
      logic                     clamped;
      logic                     clamp_neg;
   } work_type;

endpackage

### rtl/quaternion_to_euler_zyx_top.sv
// Quaternion (Q1.15 components) to ZYX Euler angles (Q3.13 radians for roll and yaw, Q2.13
// for pitch). Fully pipelined: one beat is accepted per cycle while no result is stalled. The
// pipe is three front stages for products, sums and half-plane fold plus the pitch square,
// 31 stages of the bitwise square root that feeds the arcsine, CORDIC_STEPS vectoring stages
// shared by roll, pitch and yaw, and one rounding/output stage. The whole pipe holds when a
// waiting result is stalled; req_stall is high exactly then. pitch_clamped marks beats whose
// arcsine argument reached magnitude one, with pitch forced to plus or minus pi/2.
module quaternion_to_euler_zyx_top #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int CORDIC_STEPS    = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_z,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_w,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [15:0]                rsp_roll_angle,
   output logic signed [14:0]                rsp_pitch_angle,
   output logic signed [15:0]                rsp_yaw_angle,
   output logic                              rsp_pitch_clamped
);

   logic              advance;
   q2e_pkg::work_type sq_chain [q2e_pkg::SQRT_STEPS+1];
   q2e_pkg::work_type cd_chain [CORDIC_STEPS+1];

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   q2e_front #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .quat_x   (req_quat_x),
      .quat_y   (req_quat_y),
      .quat_z   (req_quat_z),
      .quat_w   (req_quat_w),
      .work_out (sq_chain[0])
   );

   for (genvar j = 0; j < q2e_pkg::SQRT_STEPS; j++) begin : g_sqrt
      q2e_sqrt_stage #(.STEP(j)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .work_in_d (sq_chain[j]),
         .work_out  (sq_chain[j+1])
      );
   end

   assign cd_chain[0] = sq_chain[q2e_pkg::SQRT_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      q2e_cordic_stage #(.ITER(i)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .work_in_d (cd_chain[i]),
         .work_out  (cd_chain[i+1])
      );
   end

   q2e_finish u_finish (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .work_in_d         (cd_chain[CORDIC_STEPS]),
      .rsp_valid         (rsp_valid),
      .rsp_roll_angle    (rsp_roll_angle),
      .rsp_pitch_angle   (rsp_pitch_angle),
      .rsp_yaw_angle     (rsp_yaw_angle),
      .rsp_pitch_clamped (rsp_pitch_clamped)
   );

endmodule

### rtl/q2e_front.sv
module q2e_front #(
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic signed [COMPONENT_WIDTH-1:0] quat_x,
   input  logic signed [COMPONENT_WIDTH-1:0] quat_y,
   input  logic signed [COMPONENT_WIDTH-1:0] quat_z,
   input  logic signed [COMPONENT_WIDTH-1:0] quat_w,
   output q2e_pkg::work_type                 work_out
);

   localparam int CW  = COMPONENT_WIDTH;
   localparam int SH  = 2 * (CW - 1) - q2e_pkg::WFRAC;
   localparam int SHR = (SH >= 0) ? SH : 0;
   localparam int SHL = (SH < 0) ? -SH : 0;
   localparam int W   = q2e_pkg::WORK_W;

   typedef struct packed {
      logic                                 valid;
      logic signed [q2e_pkg::PROD_W-1:0]    wx, yz, xx, yy, wy, zx, wz, xy, zz;
   } prod_type;

   typedef struct packed {
      logic                valid;
      logic signed [W-1:0] sr, cr, sp, sy, cy;
      logic                clamped;
      logic                clamp_neg;
   } sum_type;

   prod_type          prod_ff, prod_in;
   sum_type           sum_ff, sum_in;
   q2e_pkg::work_type work_ff, work_in;

   // rescale to 30 fraction bits, floor on dropped bits
   function automatic logic signed [q2e_pkg::PROD_W-1:0] scale(input logic signed [2*CW-1:0] p);
      logic signed [63:0] e;
      e = 64'(p);
      e = (e >>> SHR) <<< SHL;
      return e[q2e_pkg::PROD_W-1:0];
   endfunction

   function automatic logic signed [W-1:0] ext(input logic signed [q2e_pkg::PROD_W-1:0] p);
      return W'(p);
   endfunction

   always_comb begin
      prod_in.valid = in_valid;
      prod_in.wx = scale(quat_w * quat_x);
      prod_in.yz = scale(quat_y * quat_z);
      prod_in.xx = scale(quat_x * quat_x);
      prod_in.yy = scale(quat_y * quat_y);
      prod_in.wy = scale(quat_w * quat_y);
      prod_in.zx = scale(quat_z * quat_x);
      prod_in.wz = scale(quat_w * quat_z);
      prod_in.xy = scale(quat_x * quat_y);
      prod_in.zz = scale(quat_z * quat_z);
   end

   always_comb begin
      sum_in.valid = prod_ff.valid;
      sum_in.sr = (ext(prod_ff.wx) + ext(prod_ff.yz)) <<< 1;
      sum_in.cr = q2e_pkg::ONE_W - ((ext(prod_ff.xx) + ext(prod_ff.yy)) <<< 1);
      sum_in.sp = (ext(prod_ff.wy) - ext(prod_ff.zx)) <<< 1;
      sum_in.sy = (ext(prod_ff.wz) + ext(prod_ff.xy)) <<< 1;
      sum_in.cy = q2e_pkg::ONE_W - ((ext(prod_ff.yy) + ext(prod_ff.zz)) <<< 1);
      sum_in.clamped = (sum_in.sp >= q2e_pkg::ONE_W) || (sum_in.sp <= -q2e_pkg::ONE_W);
      sum_in.clamp_neg = sum_in.sp[W-1];
   end

   logic signed [30:0]                 sp_narrow;
   logic signed [q2e_pkg::ROOT_W-1:0]  sp_sq;

   always_comb begin
      sp_narrow = sum_ff.sp[30:0];
      sp_sq     = sp_narrow * sp_narrow;
      work_in.valid = sum_ff.valid;
      // left half plane: fold by pi so the vectoring converges
      if (sum_ff.cr < 0) begin
         work_in.roll_z = (sum_ff.sr >= 0) ? q2e_pkg::PI_W : -q2e_pkg::PI_W;
         work_in.roll_x = -sum_ff.cr;
         work_in.roll_y = -sum_ff.sr;
      end else begin
         work_in.roll_z = '0;
         work_in.roll_x = sum_ff.cr;
         work_in.roll_y = sum_ff.sr;
      end
      if (sum_ff.cy < 0) begin
         work_in.yaw_z = (sum_ff.sy >= 0) ? q2e_pkg::PI_W : -q2e_pkg::PI_W;
         work_in.yaw_x = -sum_ff.cy;
         work_in.yaw_y = -sum_ff.sy;
      end else begin
         work_in.yaw_z = '0;
         work_in.yaw_x = sum_ff.cy;
         work_in.yaw_y = sum_ff.sy;
      end
      work_in.pit_x     = '0;
      work_in.pit_y     = sum_ff.sp;
      work_in.pit_z     = '0;
      work_in.rad_v     = (q2e_pkg::ROOT_W'(1) << 60) - $unsigned(sp_sq);
      work_in.rad_r     = '0;
      work_in.clamped   = sum_ff.clamped;
      work_in.clamp_neg = sum_ff.clamp_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff.valid <= 1'b0;
         sum_ff.valid  <= 1'b0;
         work_ff.valid <= 1'b0;
      end else if (advance) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         work_ff <= work_in;
      end
   end

   assign work_out = work_ff;

endmodule

### rtl/q2e_sqrt_stage.sv
module q2e_sqrt_stage #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  q2e_pkg::work_type work_in_d,
   output q2e_pkg::work_type work_out
);

   localparam int BIT_POS = 60 - 2 * STEP;

   q2e_pkg::work_type          work_ff, work_in;
   logic [q2e_pkg::ROOT_W-1:0] probe, trial;

   always_comb begin
      probe   = q2e_pkg::ROOT_W'(1) << BIT_POS;
      trial   = work_in_d.rad_r + probe;
      work_in = work_in_d;
      if (work_in_d.rad_v >= trial) begin
         work_in.rad_v = work_in_d.rad_v - trial;
         work_in.rad_r = (work_in_d.rad_r >> 1) + probe;
      end else begin
         work_in.rad_r = work_in_d.rad_r >> 1;
      end
      // root is final after the last step; earlier values are overwritten
      work_in.pit_x = $signed(work_in.rad_r[q2e_pkg::WORK_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff.valid <= 1'b0;
      end else if (advance) begin
         work_ff <= work_in;
      end
   end

   assign work_out = work_ff;

endmodule

### rtl/q2e_cordic_stage.sv
module q2e_cordic_stage #(
   parameter int ITER = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  q2e_pkg::work_type work_in_d,
   output q2e_pkg::work_type work_out
);

   localparam int W = q2e_pkg::WORK_W;

   typedef struct packed {
      logic signed [W-1:0] x, y, z;
   } lane_type;

   q2e_pkg::work_type   work_ff, work_in;
   lane_type            roll_l, yaw_l, pit_l;
   logic signed [W-1:0] angle;

   function automatic lane_type rotate(input lane_type l, input logic signed [W-1:0] a);
      lane_type r;
      r = l;
      if (l.y > 0) begin
         r.x = l.x + (l.y >>> ITER);
         r.y = l.y - (l.x >>> ITER);
         r.z = l.z + a;
      end else if (l.y < 0) begin
         r.x = l.x - (l.y >>> ITER);
         r.y = l.y + (l.x >>> ITER);
         r.z = l.z - a;
      end
      return r;
   endfunction

   always_comb begin
      angle   = $signed({8'd0, q2e_pkg::ATAN_TAB[ITER]});
      roll_l  = rotate('{work_in_d.roll_x, work_in_d.roll_y, work_in_d.roll_z}, angle);
      yaw_l   = rotate('{work_in_d.yaw_x, work_in_d.yaw_y, work_in_d.yaw_z}, angle);
      pit_l   = rotate('{work_in_d.pit_x, work_in_d.pit_y, work_in_d.pit_z}, angle);
      work_in = work_in_d;
      work_in.roll_x = roll_l.x;
      work_in.roll_y = roll_l.y;
      work_in.roll_z = roll_l.z;
      work_in.yaw_x  = yaw_l.x;
      work_in.yaw_y  = yaw_l.y;
      work_in.yaw_z  = yaw_l.z;
      work_in.pit_x  = pit_l.x;
      work_in.pit_y  = pit_l.y;
      work_in.pit_z  = pit_l.z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff.valid <= 1'b0;
      end else if (advance) begin
         work_ff <= work_in;
      end
   end

   assign work_out = work_ff;

endmodule

### rtl/q2e_finish.sv
module q2e_finish (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  q2e_pkg::work_type   work_in_d,
   output logic                rsp_valid,
   output logic signed [15:0]  rsp_roll_angle,
   output logic signed [14:0]  rsp_pitch_angle,
   output logic signed [15:0]  rsp_yaw_angle,
   output logic                rsp_pitch_clamped
);

   localparam int W = q2e_pkg::WORK_W;

   logic               valid_ff;
   logic signed [15:0] roll_ff, roll_in, yaw_ff, yaw_in;
   logic signed [14:0] pitch_ff, pitch_in;
   logic               clamp_ff;

   // round half up to 13 fraction bits, then saturate
   function automatic logic signed [W-1:0] to_q13(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] lim);
      logic signed [W-1:0] r;
      r = (a + q2e_pkg::ROUND_HALF) >>> q2e_pkg::Q13_SHIFT;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   logic signed [W-1:0] roll_w, yaw_w, pitch_w;

   always_comb begin
      roll_w = to_q13(work_in_d.roll_z, q2e_pkg::PI_Q13);
      yaw_w  = to_q13(work_in_d.yaw_z, q2e_pkg::PI_Q13);
      if (work_in_d.clamped) begin
         pitch_w = work_in_d.clamp_neg ? -q2e_pkg::HALF_PI_Q13 : q2e_pkg::HALF_PI_Q13;
      end else begin
         pitch_w = to_q13(work_in_d.pit_z, q2e_pkg::HALF_PI_Q13);
      end
      roll_in  = roll_w[15:0];
      yaw_in   = yaw_w[15:0];
      pitch_in = pitch_w[14:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= work_in_d.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         roll_ff  <= roll_in;
         yaw_ff   <= yaw_in;
         pitch_ff <= pitch_in;
         clamp_ff <= work_in_d.clamped;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_roll_angle    = roll_ff;
   assign rsp_pitch_angle   = pitch_ff;
   assign rsp_yaw_angle     = yaw_ff;
   assign rsp_pitch_clamped = clamp_ff;

endmodule

### rtl/q2e_checker.sv
module q2e_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_roll_angle,
   input logic signed [14:0] rsp_pitch_angle,
   input logic signed [15:0] rsp_yaw_angle,
   input logic               rsp_pitch_clamped
);

   // a stalled result beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped under stall");

   // pipe holds only behind a stalled result
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall not tied to result stall");

   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pitch_clamped |->
         (rsp_pitch_angle == 15'sd12868) || (rsp_pitch_angle == -15'sd12868))
      else $error("clamped pitch not at half pi");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_angle <= 16'sd25736) && (rsp_roll_angle >= -16'sd25736)
         && (rsp_yaw_angle <= 16'sd25736) && (rsp_yaw_angle >= -16'sd25736)
         && (rsp_pitch_angle <= 15'sd12868) && (rsp_pitch_angle >= -15'sd12868))
      else $error("angle out of range");

endmodule

bind quaternion_to_euler_zyx_top q2e_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_roll_angle    (rsp_roll_angle),
   .rsp_pitch_angle   (rsp_pitch_angle),
   .rsp_yaw_angle     (rsp_yaw_angle),
   .rsp_pitch_clamped (rsp_pitch_clamped)
);

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int ITEMS    = 900;
   localparam int DOG_MAX  = 3000;
   localparam int STEPS    = 16;

   typedef struct {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic               clamped;
   } angles_type;

   // vectoring atan2 at 30 fraction bits
   function automatic longint atan2_w(longint y, longint x);
      longint z;
      longint dx;
      longint dy;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? longint'(q2e_pkg::PI_W) : -longint'(q2e_pkg::PI_W);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx;
            y -= dy;
            z += longint'(q2e_pkg::ATAN_TAB[i]);
         end else if (y < 0) begin
            x -= dx;
            y += dy;
            z -= longint'(q2e_pkg::ATAN_TAB[i]);
         end
      end
      return z;
   endfunction

   function automatic longint unsigned root_of(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint round_q13(longint a, longint lim);
      longint r;
      r = (a + 65536) >>> 17;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic angles_type euler_of(logic signed [15:0] x, logic signed [15:0] y,
                                           logic signed [15:0] z, logic signed [15:0] w);
      longint qx, qy, qz, qw, sr, cr, sp, sy, cy, one;
      angles_type a;
      qx = x; qy = y; qz = z; qw = w;
      one = longint'(1) << 30;
      sr = 2 * (qw * qx + qy * qz);
      cr = one - 2 * (qx * qx + qy * qy);
      sp = 2 * (qw * qy - qz * qx);
      sy = 2 * (qw * qz + qx * qy);
      cy = one - 2 * (qy * qy + qz * qz);
      a.roll = 16'(round_q13(atan2_w(sr, cr), 25736));
      a.yaw  = 16'(round_q13(atan2_w(sy, cy), 25736));
      if (sp >= one || sp <= -one) begin
         a.clamped = 1'b1;
         a.pitch = (sp > 0) ? 15'sd12868 : -15'sd12868;
      end else begin
         a.clamped = 1'b0;
         a.pitch = 15'(round_q13(atan2_w(sp,
                   longint'(root_of((64'd1 << 60) - longint'(sp * sp)))), 12868));
      end
      return a;
   endfunction

   class angle_board;
      angles_type due[$];
      int         errors;

      function void note(logic signed [15:0] x, logic signed [15:0] y,
                         logic signed [15:0] z, logic signed [15:0] w);
         due.push_back(euler_of(x, y, z, w));
      endfunction

      function void check(angles_type got);
         angles_type e;
         if (due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat r=%0d p=%0d y=%0d c=%0d",
                                       got.roll, got.pitch, got.yaw, got.clamped);
            return;
         end
         e = due.pop_front();
         if (e.roll !== got.roll || e.pitch !== got.pitch || e.yaw !== got.yaw ||
             e.clamped !== got.clamped) begin
            errors++;
            if (errors <= 10)
               $display("mismatch exp r=%0d p=%0d y=%0d c=%0d got r=%0d p=%0d y=%0d c=%0d",
                        e.roll, e.pitch, e.yaw, e.clamped,
                        got.roll, got.pitch, got.yaw, got.clamped);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_quat_x = '0, req_quat_y = '0, req_quat_z = '0, req_quat_w = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_roll_angle;
   logic signed [14:0] rsp_pitch_angle;
   logic signed [15:0] rsp_yaw_angle;
   logic rsp_pitch_clamped;

   angle_board board = new();
   bit quiet = 1'b0;
   int dog = 0;

   always #1 clock = ~clock;

   quaternion_to_euler_zyx_top u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_quat_x, .req_quat_y, .req_quat_z,
      .req_quat_w, .rsp_valid, .rsp_stall, .rsp_roll_angle, .rsp_pitch_angle,
      .rsp_yaw_angle, .rsp_pitch_clamped
   );

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 20);
      if (!reset && rsp_valid && !rsp_stall)
         board.check('{rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle, rsp_pitch_clamped});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         dog <= 0;
      end else begin
         dog <= dog + 1;
         if (dog >= DOG_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic send_quat(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z, logic signed [15:0] w);
      while (!quiet && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_quat_x <= x;
      req_quat_y <= y;
      req_quat_z <= z;
      req_quat_w <= w;
      do @(posedge clock); while (req_stall);
      board.note(x, y, z, w);
   endtask

   task automatic send_random();
      if ($urandom_range(99) < 65)
         // components within +/-0.5 keep the norm at or below one
         send_quat(16'($signed($urandom_range(32767)) - 16384),
                   16'($signed($urandom_range(32767)) - 16384),
                   16'($signed($urandom_range(32767)) - 16384),
                   16'($signed($urandom_range(32767)) - 16384));
      else
         send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed beats
      send_quat(0, 0, 0, 0);
      send_quat(0, 0, 0, 32767);
      send_quat(0, 0, 0, -32768);
      send_quat(32767, 0, 0, 0);        // negative cosine, zero sine: roll at pi
      send_quat(0, 0, 32767, 0);
      send_quat(-32768, 0, 0, 0);
      send_quat(0, 23170, 0, 23170);    // near gimbal lock, positive
      send_quat(0, -23170, 0, 23170);   // near gimbal lock, negative
      send_quat(23170, 0, 23170, 0);
      send_quat(16384, 16384, 16384, 16384);
      send_quat(32767, 32767, 32767, 32767);
      send_quat(-32768, -32768, -32768, -32768);
      send_quat(32767, -32768, 32767, -32768);
      send_quat(-32768, 32767, -32768, 32767);
      send_quat(0, 16000, 0, 16000);
      send_quat(0, 23169, 0, 23169);
      send_quat(12000, 0, 0, 30000);
      send_quat(0, 0, 12000, -30000);
      send_quat(-1, -1, -1, -1);
      send_quat(1, 1, 1, 1);
      for (int i = 0; i < ITEMS; i++) begin
         quiet = (i >= 300 && i < 450);
         if (i == 600) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (board.due.size() != 0) @(posedge clock);
         end
         send_random();
      end
      quiet = 1'b0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.due.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.errors == 0 && board.due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
